FILE: rtl/hcd_pkg.sv
package hcd_pkg;

  localparam int unsigned LengthBitsDef = 32;

  // "Content-Length:" is fifteen characters
  localparam int unsigned KeyLen = 15;
  localparam logic [3:0] KeyLast = 4'(KeyLen - 1);

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharBigC  = 8'h43;

  // result fields: complete, header_end_seen, length_found, two 32-bit counts
  localparam int unsigned OutFieldBits = 3 + 32 + 32;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhBlanks = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/http_message_completeness_detector_top.sv
// channel  | direction | tdata (low bit up)                          | tuser
// ---------+-----------+---------------------------------------------+-----------------
// s_axis   | in        | data_byte[7:0]                              | start_of_message
// m_axis   | out       | complete, header_end_seen, length_found,    | -
//          |           | declared_length[31:0], body_count[31:0], 0s |
//
// one byte per cycle sustained while the output is not stalled; a byte passes the input register,
// then the tracking logic, and its result is then registered in the result register
// rst_ni clears all tracking state; start_of_message clears it again before its byte
// a stalled output holds the result; the input register still takes one more byte
module http_message_completeness_detector_top #(
  parameter int unsigned LENGTH_BITS = hcd_pkg::LengthBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // data_byte
  input  logic                             s_axis_tuser,  // start_of_message
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // complete, header_end_seen, length_found, declared_length, body_count, zero fill
  output logic [hcd_pkg::OutDataBits-1:0] m_axis_tdata
);

  localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_som_q;

  // tracking state
  hcd_pkg::phase_e    phase_q, phase_d, cur_phase;
  logic [3:0]         pos_q, pos_d, cur_pos;
  logic [LENGTH_BITS-1:0] val_q, val_d, cur_val;
  logic [1:0]         crlf_q, crlf_d, cur_crlf;
  logic               hdone_q, hdone_d, cur_hdone;
  logic [LENGTH_BITS-1:0] body_q, body_d, cur_body;

  // result register
  logic                            out_valid_q;
  logic [hcd_pkg::OutDataBits-1:0] out_data_q, out_data_d;

  logic                   advance;
  logic                   is_digit, is_blank;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] acc_wide;
  logic [LENGTH_BITS-1:0] acc_next;
  logic [3:0]             restart;
  logic                   found;
  logic [LENGTH_BITS-1:0] declared;
  logic                   complete;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // start of message clears tracking before the byte is used
  always_comb begin
    if (in_som_q) begin
      cur_phase = hcd_pkg::PhSearch;
      cur_pos   = '0;
      cur_val   = '0;
      cur_crlf  = '0;
      cur_hdone = 1'b0;
      cur_body  = '0;
    end else begin
      cur_phase = phase_q;
      cur_pos   = pos_q;
      cur_val   = val_q;
      cur_crlf  = crlf_q;
      cur_hdone = hdone_q;
      cur_body  = body_q;
    end
  end

  assign is_digit = (in_byte_q >= hcd_pkg::CharZero) && (in_byte_q <= hcd_pkg::CharNine);
  assign is_blank = (in_byte_q == hcd_pkg::CharSpace) || (in_byte_q == hcd_pkg::CharTab);
  assign digit    = 4'(in_byte_q - hcd_pkg::CharZero);
  assign restart  = (in_byte_q == hcd_pkg::CharBigC) ? 4'd1 : 4'd0;

  // value * 10 + digit, saturating when the top bits spill over
  assign acc_wide = ({4'b0, cur_val} << 3) + ({4'b0, cur_val} << 1)
                  + (LENGTH_BITS+4)'(digit);
  assign acc_next = (acc_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                  ? CountMax : acc_wide[LENGTH_BITS-1:0];

  // next state of the length tracker, the header end search and the body count
  always_comb begin
    phase_d = cur_phase;
    pos_d   = cur_pos;
    val_d   = cur_val;
    crlf_d  = cur_crlf;
    hdone_d = cur_hdone;
    body_d  = cur_body;
    if (cur_hdone) begin
      if (cur_body != CountMax) begin
        body_d = cur_body + LENGTH_BITS'(1);
      end
    end else begin
      case (cur_phase)
        hcd_pkg::PhSearch: begin
          if (in_byte_q == hcd_pkg::key_char(cur_pos)) begin
            if (cur_pos == hcd_pkg::KeyLast) begin
              phase_d = hcd_pkg::PhBlanks;
              pos_d   = '0;
            end else begin
              pos_d = cur_pos + 4'd1;
            end
          end else begin
            pos_d = restart;
          end
        end
        hcd_pkg::PhBlanks: begin
          if (!is_blank) begin
            if (is_digit) begin
              phase_d = hcd_pkg::PhDigits;
              val_d   = LENGTH_BITS'(digit);
            end else begin
              phase_d = hcd_pkg::PhSearch;
              pos_d   = restart;
            end
          end
        end
        hcd_pkg::PhDigits: begin
          if (is_digit) begin
            val_d = acc_next;
          end else begin
            phase_d = hcd_pkg::PhDone;
          end
        end
        default: begin
        end
      endcase
      // cr lf cr lf: even steps want cr, odd steps want lf
      if (in_byte_q == (cur_crlf[0] ? hcd_pkg::CharLf : hcd_pkg::CharCr)) begin
        if (cur_crlf == 2'd3) begin
          hdone_d = 1'b1;
          crlf_d  = '0;
        end else begin
          crlf_d = cur_crlf + 2'd1;
        end
      end else begin
        crlf_d = (in_byte_q == hcd_pkg::CharCr) ? 2'd1 : 2'd0;
      end
    end
  end

  // result fields
  always_comb begin
    found      = (phase_d == hcd_pkg::PhDigits) || (phase_d == hcd_pkg::PhDone);
    declared   = found ? val_d : '0;
    complete   = hdone_d && (body_d == declared);
    out_data_d = '0;
    out_data_d[0]     = complete;
    out_data_d[1]     = hdone_d;
    out_data_d[2]     = found;
    out_data_d[34:3]  = 32'(declared);
    out_data_d[66:35] = 32'(body_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= hcd_pkg::PhSearch;
      pos_q       <= '0;
      val_q       <= '0;
      crlf_q      <= '0;
      hdone_q     <= 1'b0;
      body_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        val_q       <= val_d;
        crlf_q      <= crlf_d;
        hdone_q     <= hdone_d;
        body_q      <= body_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_som_q  <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: test/testbench.sv
module testbench;

  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic        complete;
    logic        header_end_seen;
    logic        length_found;
    logic [31:0] declared_length;
    logic [31:0] body_count;
  } msg_status_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;  // data_byte
  logic                   s_axis_tuser;  // start_of_message
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // complete, header_end_seen, length_found, declared_length, body_count, zero fill
  logic [hcd_pkg::OutDataBits-1:0] m_axis_tdata;

  http_message_completeness_detector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // expected status per byte, oldest first
  msg_status_t status_q[$];
  msg_status_t want_status;
  logic [7:0]  msg_buf[$];

  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  int unsigned send_idle_pct  = 9;
  int unsigned recv_stall_pct = 82;

  // tracking state of the predictor
  logic [3:0]       key_pos;
  hcd_pkg::phase_e  len_phase;
  logic [31:0]      len_val;
  logic [2:0]       crlf_pos;
  logic             hdr_done;
  logic [31:0]      body_bytes;
  string            key_text = "Content-Length:";

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_tracking();
    key_pos    = 4'd0;
    len_phase  = hcd_pkg::PhSearch;
    len_val    = 32'd0;
    crlf_pos   = 3'd0;
    hdr_done   = 1'b0;
    body_bytes = 32'd0;
  endfunction

  function automatic msg_status_t track_byte(input logic [7:0] b, input logic som);
    logic        is_digit;
    logic [63:0] acc;
    logic [7:0]  crlf_want;
    logic        found;
    msg_status_t st;
    if (som) clear_tracking();
    is_digit = (b >= hcd_pkg::CharZero) && (b <= hcd_pkg::CharNine);
    if (hdr_done) begin
      if (body_bytes != 32'hffff_ffff) body_bytes = body_bytes + 32'd1;
    end else begin
      case (len_phase)
        hcd_pkg::PhSearch: begin
          if (key_pos < 4'(hcd_pkg::KeyLen) && b == key_text[key_pos]) begin
            key_pos = key_pos + 4'd1;
            if (key_pos == 4'(hcd_pkg::KeyLen)) begin
              len_phase = hcd_pkg::PhBlanks;
              key_pos   = 4'd0;
            end
          end else begin
            key_pos = (b == hcd_pkg::CharBigC) ? 4'd1 : 4'd0;
          end
        end
        hcd_pkg::PhBlanks: begin
          if (b != hcd_pkg::CharSpace && b != hcd_pkg::CharTab) begin
            if (is_digit) begin
              len_phase = hcd_pkg::PhDigits;
              len_val   = 32'(b - hcd_pkg::CharZero);
            end else begin
              len_phase = hcd_pkg::PhSearch;
              key_pos   = (b == hcd_pkg::CharBigC) ? 4'd1 : 4'd0;
            end
          end
        end
        hcd_pkg::PhDigits: begin
          if (is_digit) begin
            acc = 64'(len_val) * 64'd10 + 64'(b - hcd_pkg::CharZero);
            len_val = (acc > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : acc[31:0];
          end else begin
            len_phase = hcd_pkg::PhDone;
          end
        end
        default: ;
      endcase
      // blank line is CR LF CR LF
      crlf_want = crlf_pos[0] ? hcd_pkg::CharLf : hcd_pkg::CharCr;
      if (b == crlf_want) begin
        crlf_pos = crlf_pos + 3'd1;
        if (crlf_pos == 3'd4) begin
          hdr_done = 1'b1;
          crlf_pos = 3'd0;
        end
      end else begin
        crlf_pos = (b == hcd_pkg::CharCr) ? 3'd1 : 3'd0;
      end
    end
    found              = (len_phase == hcd_pkg::PhDigits) || (len_phase == hcd_pkg::PhDone);
    st.length_found    = found;
    st.declared_length = found ? len_val : 32'd0;
    st.header_end_seen = hdr_done;
    st.body_count      = body_bytes;
    st.complete        = hdr_done && (body_bytes == st.declared_length);
    return st;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result transaction with nothing expected: %h", m_axis_tdata);
      end else begin
        want_status = status_q.pop_front();
        check_field("complete", 32'(want_status.complete), 32'(m_axis_tdata[0]));
        check_field("header_end_seen", 32'(want_status.header_end_seen),
                    32'(m_axis_tdata[1]));
        check_field("length_found", 32'(want_status.length_found), 32'(m_axis_tdata[2]));
        check_field("declared_length", want_status.declared_length, m_axis_tdata[34:3]);
        check_field("body_count", want_status.body_count, m_axis_tdata[66:35]);
        check_field("zero fill", 32'd0, 32'(m_axis_tdata[hcd_pkg::OutDataBits-1:67]));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic som);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= som;
    do @(posedge clk_i); while (!s_axis_tready);
    status_q.push_back(track_byte(b, som));
  endtask

  task automatic send_text(input string s, input logic som);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], som && (i == 0));
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endfunction

  function automatic void add_header_line();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      msg_buf.push_back(($urandom_range(3) == 0) ? hcd_pkg::CharBigC
                                                 : 8'($urandom_range(97, 122)));
    add_text(": ");
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(32, 126)));
    add_text("\015\012");
  endfunction

  // one request: mostly well formed with random content, some noise and broken ones
  function automatic void build_message();
    int unsigned n_hdr;
    int unsigned len_slot;
    int unsigned decl;
    int          body_len;
    logic        has_len;
    logic        big_len;
    msg_buf.delete();
    if ($urandom_range(99) < 15) begin
      n_hdr = $urandom_range(4, 40);
      for (int i = 0; i < n_hdr; i++) begin
        case ($urandom_range(9))
          0:       msg_buf.push_back(hcd_pkg::CharCr);
          1:       msg_buf.push_back(hcd_pkg::CharLf);
          default: msg_buf.push_back(8'($urandom_range(255)));
        endcase
      end
      return;
    end
    add_text("POST /");
    n_hdr = $urandom_range(0, 5);
    for (int i = 0; i < n_hdr; i++) msg_buf.push_back(8'($urandom_range(97, 122)));
    add_text(" HTTP/1.1\015\012");
    n_hdr    = $urandom_range(0, 3);
    len_slot = $urandom_range(0, n_hdr);
    has_len  = ($urandom_range(99) < 80);
    big_len  = ($urandom_range(99) < 5);
    decl     = $urandom_range(0, 24);
    for (int i = 0; i <= n_hdr; i++) begin
      if (has_len && i == len_slot) begin
        if ($urandom_range(9) == 0) begin
          add_text("Content-Lengt");
          add_text(($urandom_range(1) == 0) ? "C: 3" : "x: 3");
        end else begin
          add_text("Content-Length:");
          for (int k = $urandom_range(0, 2); k > 0; k--)
            msg_buf.push_back(($urandom_range(1) == 0) ? hcd_pkg::CharSpace
                                                       : hcd_pkg::CharTab);
          if (big_len) begin
            for (int k = $urandom_range(8, 12); k > 0; k--)
              msg_buf.push_back(8'(hcd_pkg::CharZero + $urandom_range(9)));
          end else begin
            if ($urandom_range(7) == 0) add_text("0");
            add_text($sformatf("%0d", decl));
          end
        end
        add_text("\015\012");
      end else begin
        add_header_line();
      end
    end
    add_text("\015\012");
    body_len = big_len ? $urandom_range(0, 6) : int'(decl) + $urandom_range(0, 3) - 1;
    if (!has_len) body_len = $urandom_range(0, 3);
    for (int i = 0; i < body_len; i++) msg_buf.push_back(8'($urandom_range(255)));
    // cut short now and then
    if ($urandom_range(9) == 0) begin
      n_hdr = $urandom_range(1, msg_buf.size());
      while (msg_buf.size() > n_hdr) void'(msg_buf.pop_back());
    end
  endfunction

  task automatic send_message();
    for (int i = 0; i < msg_buf.size(); i++) send_byte(msg_buf[i], i == 0);
  endtask

  task automatic test_directed();
    // restart on a repeated C, tab and space blanks, body with extreme bytes
    send_text("CContent-Length:\t 3\015\012\015\012", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    // blanks then a non-digit, a later header counts, an extra CR restarts the CR LF CR LF search
    send_text("Content-Length: x\015\012Content-Length:2\015\015\012\015\012ab!", 1'b1);
    // saturating length
    send_text("Content-Length: 99999999999\015\012\015\012z", 1'b1);
    // header after the blank line is only body
    send_text("\015\012\015\012Content-Length: 0", 1'b1);
    // only the first header with digits counts
    send_text("Content-Length: 1\015\012Content-Length: 4\015\012\015\012q", 1'b1);
    // new message in the middle of a key
    send_text("Content-Len", 1'b1);
    send_text("X\015\012\015\012", 1'b1);
    drain_results();
  endtask

  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned n_bytes);
    int unsigned sent;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent           = 0;
    while (sent < n_bytes) begin
      build_message();
      send_message();
      sent += msg_buf.size();
      if ($urandom_range(19) == 0) drain_results();
    end
    drain_results();
  endtask

  // output held off long enough that the input side backs up
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 64;
    send_text("Content-Length: 6\015\012Host: x\015\012\015\012", 1'b1);
    send_text("abcdef", 1'b0);
    drain_results();
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    clear_tracking();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(9, 82, 80);
    test_random(82, 9, 80);
    test_output_stall();
    test_random(0, 0, 80);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
